>>> src/smmm_pkg.sv
// Shared types and constants for the set min/max/median block.
// Used by smmm_ctrl, smmm_datapath and set_min_max_median; depends on nothing.
`default_nettype none

package smmm_pkg;

   localparam int VALUE_W       = 32;
   localparam int SIZE_W        = 7;
   localparam int MAX_ITEMS_DEF = 64;

   // Store write data select.
   localparam logic [1:0] WSEL_SAMPLE = 2'd0;
   localparam logic [1:0] WSEL_MIN    = 2'd1;
   localparam logic [1:0] WSEL_CARRY  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample_value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] min_value;
      logic signed [VALUE_W-1:0] max_value;
      logic signed [VALUE_W-1:0] median_value;
      logic [SIZE_W-1:0]         set_size;
      logic                      overflow_flag;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              we;
      logic              re;
      logic [1:0]        wsel;
      logic              track;
      logic              track_first;
      logic              carry_load;
      logic              carry_step;
      logic              grab_lo;
      logic              grab_sum;
      logic              rsp_load;
      logic [SIZE_W-1:0] set_size;
      logic              overflow;
   } cmd_type;

endpackage

`default_nettype wire

>>> src/smmm_datapath.sv
// Datapath of the set min/max/median block: value store, compare-exchange
// unit, running min/max, median adder and result register. Uses smmm_pkg.
`default_nettype none

module smmm_datapath #(
   parameter int MAX_ITEMS = smmm_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                     clock,
   input  wire smmm_pkg::req_type        req_data,
   input  wire smmm_pkg::cmd_type        cmd,
   input  wire logic [$clog2(MAX_ITEMS)-1:0] waddr,
   input  wire logic [$clog2(MAX_ITEMS)-1:0] raddr,
   output smmm_pkg::rsp_type             rsp_data
);

   localparam int VW = smmm_pkg::VALUE_W;

   logic signed [VW-1:0] store_ff [MAX_ITEMS];
   logic signed [VW-1:0] rd_data_ff;
   logic signed [VW-1:0] carry_ff, carry_in;
   logic signed [VW-1:0] min_ff, min_in;
   logic signed [VW-1:0] max_ff, max_in;
   logic signed [VW-1:0] mid_lo_ff, mid_lo_in;
   logic signed [VW:0]   sum_ff, sum_in;
   logic signed [VW:0]   sum_adj;
   logic signed [VW-1:0] cmp_lo, cmp_hi, wdata;
   logic                 lt;
   smmm_pkg::rsp_type    rsp_ff, rsp_in;

   // Compare-exchange: the smaller value is written back, the larger one
   // is carried on up the store.
   assign lt     = rd_data_ff < carry_ff;
   assign cmp_lo = lt ? rd_data_ff : carry_ff;
   assign cmp_hi = lt ? carry_ff : rd_data_ff;

   always_comb begin
      unique case (cmd.wsel)
         smmm_pkg::WSEL_SAMPLE: wdata = req_data.sample_value;
         smmm_pkg::WSEL_MIN:    wdata = cmp_lo;
         smmm_pkg::WSEL_CARRY:  wdata = carry_ff;
         default:               wdata = req_data.sample_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         store_ff[waddr] <= wdata;
      end
      if (cmd.re) begin
         rd_data_ff <= store_ff[raddr];
      end
   end

   always_comb begin
      carry_in = carry_ff;
      if (cmd.carry_load) begin
         carry_in = rd_data_ff;
      end else if (cmd.carry_step) begin
         carry_in = cmp_hi;
      end

      min_in = min_ff;
      max_in = max_ff;
      if (cmd.track) begin
         if (cmd.track_first || (req_data.sample_value < min_ff)) begin
            min_in = req_data.sample_value;
         end
         if (cmd.track_first || (req_data.sample_value > max_ff)) begin
            max_in = req_data.sample_value;
         end
      end

      mid_lo_in = cmd.grab_lo ? rd_data_ff : mid_lo_ff;
      sum_in    = cmd.grab_sum ? ({mid_lo_ff[VW-1], mid_lo_ff} + {rd_data_ff[VW-1], rd_data_ff})
                               : sum_ff;
   end

   // Halving with truncation toward zero: bump a negative sum by one first.
   // For an odd count both middles are the same element, so this gives it back.
   assign sum_adj = sum_ff + {{VW{1'b0}}, sum_ff[VW]};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.min_value     = min_ff;
         rsp_in.max_value     = max_ff;
         rsp_in.median_value  = sum_adj[VW:1];
         rsp_in.set_size      = cmd.set_size;
         rsp_in.overflow_flag = cmd.overflow;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff  <= carry_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      mid_lo_ff <= mid_lo_in;
      sum_ff    <= sum_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // The running min never exceeds the running max once a set has begun.
   property p_min_le_max;
      @(posedge clock) cmd.rsp_load |-> (min_ff <= max_ff);
   endproperty
   a_min_le_max: assert property (p_min_le_max)
      else $error("smmm_datapath: min above max at result load");

   property p_single_wsel;
      @(posedge clock) cmd.we |-> (cmd.wsel == smmm_pkg::WSEL_SAMPLE
         || cmd.wsel == smmm_pkg::WSEL_MIN || cmd.wsel == smmm_pkg::WSEL_CARRY);
   endproperty
   a_single_wsel: assert property (p_single_wsel)
      else $error("smmm_datapath: store write with undefined data select");

   property p_load_not_during_sort;
      @(posedge clock) cmd.track |-> !(cmd.carry_load || cmd.carry_step || cmd.re);
   endproperty
   a_load_not_during_sort: assert property (p_load_not_during_sort)
      else $error("smmm_datapath: request loaded while sorting");

endmodule

`default_nettype wire

>>> src/smmm_ctrl.sv
// Controller of the set min/max/median block: request and result handshakes,
// fill count, sort pass sequencer and median read-out. Uses smmm_pkg.
`default_nettype none

module smmm_ctrl #(
   parameter int MAX_ITEMS = smmm_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output smmm_pkg::cmd_type                 cmd,
   output logic [$clog2(MAX_ITEMS)-1:0]      waddr,
   output logic [$clog2(MAX_ITEMS)-1:0]      raddr
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PASS_READ = 3'd1;
   localparam logic [2:0] ST_PASS_RUN  = 3'd2;
   localparam logic [2:0] ST_PASS_END  = 3'd3;
   localparam logic [2:0] ST_MID_LO    = 3'd4;
   localparam logic [2:0] ST_MID_HI    = 3'd5;
   localparam logic [2:0] ST_MID_SUM   = 3'd6;
   localparam logic [2:0] ST_EMIT      = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [AW-1:0] end_ff, end_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          full;
   logic [AW-1:0] mid_lo, mid_hi;
   logic [CW-1:0] count_dec;

   assign full      = (count_ff == CW'(MAX_ITEMS));
   assign count_dec = count_ff - CW'(1);
   assign mid_lo    = AW'(count_dec >> 1);
   assign mid_hi    = AW'(count_ff >> 1);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      end_in     = end_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      waddr      = '0;
      raddr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!full) begin
                  cmd.we          = 1'b1;
                  cmd.wsel        = smmm_pkg::WSEL_SAMPLE;
                  cmd.track       = 1'b1;
                  cmd.track_first = (count_ff == '0);
                  waddr           = count_ff[AW-1:0];
                  count_in        = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  // Top index of the set once this request is counted.
                  end_in   = full ? AW'(count_dec) : count_ff[AW-1:0];
                  state_in = ST_PASS_READ;
               end
            end
         end
         ST_PASS_READ: begin
            cmd.re   = 1'b1;
            raddr    = '0;
            idx_in   = '0;
            state_in = ST_PASS_RUN;
         end
         ST_PASS_RUN: begin
            if (idx_ff == '0) begin
               cmd.carry_load = 1'b1;
            end else begin
               cmd.we         = 1'b1;
               cmd.wsel       = smmm_pkg::WSEL_MIN;
               cmd.carry_step = 1'b1;
               waddr          = idx_ff - AW'(1);
            end
            if (idx_ff != end_ff) begin
               cmd.re = 1'b1;
               raddr  = idx_ff + AW'(1);
               idx_in = idx_ff + AW'(1);
            end else begin
               state_in = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            // The largest value of this pass settles at the top of the range.
            cmd.we   = 1'b1;
            cmd.wsel = smmm_pkg::WSEL_CARRY;
            waddr    = end_ff;
            if (end_ff == mid_lo) begin
               state_in = ST_MID_LO;
            end else begin
               end_in   = end_ff - AW'(1);
               state_in = ST_PASS_READ;
            end
         end
         ST_MID_LO: begin
            cmd.re   = 1'b1;
            raddr    = mid_lo;
            state_in = ST_MID_HI;
         end
         ST_MID_HI: begin
            cmd.grab_lo = 1'b1;
            cmd.re      = 1'b1;
            raddr       = mid_hi;
            state_in    = ST_MID_SUM;
         end
         ST_MID_SUM: begin
            cmd.grab_sum = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.set_size = smmm_pkg::SIZE_W'(count_ff);
               cmd.overflow = dropped_ff;
               count_in     = '0;
               dropped_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
      endcase

      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      idx_ff <= idx_in;
   end

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CW'(MAX_ITEMS);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("smmm_ctrl: fill count beyond capacity");

   property p_idx_in_range;
      @(posedge clock) disable iff (reset) (state_ff == ST_PASS_RUN) |-> (idx_ff <= end_ff);
   endproperty
   a_idx_in_range: assert property (p_idx_in_range)
      else $error("smmm_ctrl: pass index past end of range");

   property p_end_above_mid;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_PASS_READ || state_ff == ST_PASS_RUN || state_ff == ST_PASS_END)
         |-> (end_ff >= mid_lo);
   endproperty
   a_end_above_mid: assert property (p_end_above_mid)
      else $error("smmm_ctrl: sort went below the lower middle");

   property p_clear_after_result;
      @(posedge clock) disable iff (reset) cmd.rsp_load |=> (count_ff == '0 && !dropped_ff);
   endproperty
   a_clear_after_result: assert property (p_clear_after_result)
      else $error("smmm_ctrl: set not cleared after result");

endmodule

`default_nettype wire

>>> src/set_min_max_median.sv
// Top level of the set min/max/median block: joins smmm_ctrl and smmm_datapath.
// Uses smmm_pkg for the request, result and command types.
//
// Requests arrive on req_valid/req_ready/req_data, one signed value each; the
// request with last_item set closes the set. Up to MAX_ITEMS values are stored;
// later ones are dropped and reported through overflow_flag. Each set yields
// one result on rsp_valid/rsp_ready/rsp_data with min, max, median and count.
// Loading takes one request per cycle. After the last request the store is
// sorted in place by bubble passes through its single read and write port:
// passes over indices 0..e run for e = n-1 down to (n-1)/2; then the two middle
// values are read, their sum is formed and the result register is loaded.
// Min and max are tracked while loading; the median is the truncated mean of
// the two middle values, which is the middle value itself for an odd count.
// While sorting, req_ready is low. The result sits in an output register, so
// a stalled receiver does not stop loading of the next set; only the next
// result waits for the register to empty. Reset empties the set and drops any
// pending result; the store itself needs no clearing.
`default_nettype none

module set_min_max_median #(
   parameter int MAX_ITEMS = smmm_pkg::MAX_ITEMS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire smmm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output smmm_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);

   smmm_pkg::cmd_type cmd;
   logic [AW-1:0]     waddr;
   logic [AW-1:0]     raddr;

   smmm_ctrl #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .waddr     (waddr),
      .raddr     (raddr)
   );

   smmm_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .waddr    (waddr),
      .raddr    (raddr),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> bench/tb_set_min_max_median.sv
// Self-checking testbench for set_min_max_median: directed and random sets of signed
// values, with predicted min, max, median, count and overflow checked per result.
// Depends on smmm_pkg and the set_min_max_median RTL.
`default_nettype none

module tb_set_min_max_median;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY        = smmm_pkg::MAX_ITEMS_DEF;
   localparam int RANDOM_ITEMS    = 1900;
   localparam int HOLD_OFF_CYCLES = 2500;
   // The quiet limit must cover sorting a full store plus the long receiver
   // hold-off; it is several times their sum.
   localparam int QUIET_LIMIT     = 20000;
   localparam int DRAIN_CYCLES    = 100;

   localparam logic signed [smmm_pkg::VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [smmm_pkg::VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

   class stats_scoreboard;
      logic signed [smmm_pkg::VALUE_W-1:0] held_values[CAPACITY];
      int unsigned                         held_count;
      bit                                  dropped;
      smmm_pkg::rsp_type                   pending_stats[$];
      int                                  errors;

      function new();
         held_count = 0;
         dropped    = 0;
         errors     = 0;
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      // Stores the value (or marks it dropped) and, on the last request of a
      // set, sorts the stored values and queues the statistics they give.
      function void note_request(input smmm_pkg::req_type r);
         logic signed [smmm_pkg::VALUE_W-1:0] key;
         int unsigned                         j;
         longint                              pair_half;
         smmm_pkg::rsp_type                   stats;
         if (held_count < CAPACITY) begin
            held_values[held_count] = r.sample_value;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!r.last_item) return;
         for (int unsigned i = 1; i < held_count; i++) begin
            key = held_values[i];
            j   = i;
            while (j > 0 && held_values[j-1] > key) begin
               held_values[j] = held_values[j-1];
               j--;
            end
            held_values[j] = key;
         end
         stats.min_value = held_values[0];
         stats.max_value = held_values[held_count-1];
         if (held_count % 2 == 1) begin
            stats.median_value = held_values[held_count/2];
         end else begin
            // The sum needs 33 bits; longint division truncates toward zero.
            pair_half = (longint'(held_values[held_count/2-1]) +
                         longint'(held_values[held_count/2])) / 2;
            stats.median_value = pair_half[smmm_pkg::VALUE_W-1:0];
         end
         stats.set_size      = held_count[smmm_pkg::SIZE_W-1:0];
         stats.overflow_flag = dropped;
         pending_stats.push_back(stats);
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      task check_result(input smmm_pkg::rsp_type got);
         smmm_pkg::rsp_type want;
         if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: %p", got));
            return;
         end
         want = pending_stats.pop_front();
         if (got.min_value !== want.min_value)
            report_mismatch($sformatf("min_value %0d, predicted %0d",
                                      got.min_value, want.min_value));
         if (got.max_value !== want.max_value)
            report_mismatch($sformatf("max_value %0d, predicted %0d",
                                      got.max_value, want.max_value));
         if (got.median_value !== want.median_value)
            report_mismatch($sformatf("median_value %0d, predicted %0d",
                                      got.median_value, want.median_value));
         if (got.set_size !== want.set_size)
            report_mismatch($sformatf("set_size %0d, predicted %0d",
                                      got.set_size, want.set_size));
         if (got.overflow_flag !== want.overflow_flag)
            report_mismatch($sformatf("overflow_flag %0b, predicted %0b",
                                      got.overflow_flag, want.overflow_flag));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   smmm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   smmm_pkg::rsp_type rsp_data;

   stats_scoreboard board = new();

   int results_seen = 0;
   int quiet_cycles = 0;
   int burst_left   = 0;
   bit steady       = 1'b0;

   set_min_max_median DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Offers one request and waits for it to be taken. Bursts of random
   // length are separated by random gaps unless the sender runs steady.
   task automatic push_request(input logic signed [smmm_pkg::VALUE_W-1:0] value,
                               input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady) pause_sender($urandom_range(1, 8));
      end
      burst_left--;
      @(negedge clock);
      req_valid              = 1'b1;
      req_data.sample_value  = value;
      req_data.last_item     = last;
      do @(posedge clock); while (!req_ready);
      board.note_request(req_data);
   endtask

   function automatic logic signed [smmm_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return MOST_NEG + $urandom_range(0, 15);
         3:       return MOST_POS - $urandom_range(0, 15);
         4:       return $urandom_range(0, 40) - 20;
         default: return $urandom();
      endcase
   endfunction

   // Shapes: random content, ascending runs, descending runs and heavy
   // duplicates, so that the sort sees its best and worst orders.
   task automatic send_set(input int count, input int shape);
      logic signed [smmm_pkg::VALUE_W-1:0] base;
      logic signed [smmm_pkg::VALUE_W-1:0] stride;
      logic signed [smmm_pkg::VALUE_W-1:0] value;
      base   = pick_value();
      stride = $urandom_range(0, 1000);
      for (int i = 0; i < count; i++) begin
         case (shape)
            1:       value = base + i * stride;
            2:       value = base - i * stride;
            3:       value = $urandom_range(0, 1) ? base : base + 1;
            default: value = pick_value();
         endcase
         push_request(value, i == count - 1);
      end
   endtask

   initial begin
      int items_sent;
      int set_index;
      int count;
      int size_roll;
      items_sent = 0;
      set_index  = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single values at both extremes, even sets whose sum needs 33 bits,
      // negative and positive odd sums that must truncate toward zero.
      push_request(MOST_NEG, 1'b1);
      push_request(MOST_POS, 1'b1);
      push_request(0, 1'b1);
      push_request(MOST_POS, 1'b0);
      push_request(MOST_POS, 1'b1);
      push_request(MOST_NEG, 1'b0);
      push_request(MOST_NEG, 1'b1);
      push_request(MOST_POS, 1'b0);
      push_request(MOST_NEG, 1'b1);
      push_request(-3, 1'b0);
      push_request(0, 1'b1);
      push_request(3, 1'b0);
      push_request(0, 1'b1);
      push_request(32'sh5555_5555, 1'b0);
      push_request(32'shAAAA_AAAA, 1'b1);
      push_request(7, 1'b0);
      push_request(-5, 1'b0);
      push_request(2, 1'b1);
      push_request(4, 1'b0);
      push_request(3, 1'b0);
      push_request(2, 1'b0);
      push_request(1, 1'b1);

      // Mostly small sets; a few fill the store exactly or run past it.
      while (items_sent < RANDOM_ITEMS) begin
         size_roll = $urandom_range(0, 99);
         if (set_index == 0)      count = CAPACITY + 2;
         else if (set_index == 1) count = CAPACITY;
         else if (size_roll < 70) count = $urandom_range(1, 8);
         else if (size_roll < 90) count = $urandom_range(9, 30);
         else if (size_roll < 95) count = $urandom_range(31, CAPACITY - 1);
         else if (size_roll < 97) count = CAPACITY;
         else                     count = $urandom_range(CAPACITY + 1, CAPACITY + 8);
         steady = ($urandom_range(0, 3) == 0);
         send_set(count, $urandom_range(0, 5));
         items_sent += count;
         set_index++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // The receiver changes its stall pattern every so often, and once, after
   // a few results, holds off long enough for the block to back up.
   initial begin
      int mode;
      int span;
      int phase;
      bit held_off;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         if (!held_off && results_seen >= 20) begin
            held_off = 1'b1;
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         for (phase = 0; phase < span; phase++) begin
            @(negedge clock);
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = $urandom_range(0, 1);
               2:       rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = (phase % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
